/* design/mss_pkg.sv */
// Package for the shared-store multi-stack block: request and status codes,
// field widths and the result record passed to the output register.
// No dependencies.
`default_nettype none

package mss_pkg;

	localparam int unsigned ValueW   = 32;
	localparam int unsigned StackIdW = 2;
	localparam int unsigned NumIds   = 1 << StackIdW;

	// Request kinds carried in s_tuser.
	localparam logic ReqPush = 1'b0;
	localparam logic ReqPop  = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic              now_empty;
		logic [ValueW-1:0] top_value;
		logic [ValueW-1:0] popped_value;
		status_t           status;
	} result_t;

endpackage

`default_nettype wire

/* design/multi_stack_shared_store.sv */
// Top level: several LIFO stacks sharing one slot store through linked slots
// and a free list. Depends on mss_pkg, mss_slot_ram and mss_out_reg.
//
//  channel  dir  handshake          payload (lowest bit first)
//  s_*      in   s_tvalid/s_tready  tuser: req_type; tdata: stack_id, push_value
//  m_*      out  m_tvalid/m_tready  tdata: status, popped_value, top_value, now_empty
//
// Each request is handled in S_IDLE, where the accept issues one read of the link
// and data memories, and then in S_EXEC, which applies the read-modify-write and
// loads the result into the output register. That memory read latency sets the rate.
// S_EXEC waits while the output register is still full and not taken.
// Reset clears the stack tops, the free-list head and the link fill count; the
// link memory itself needs no clearing pass, links past the fill count read as
// the next slot.
`default_nettype none

module multi_stack_shared_store #(
	parameter int unsigned NUM_STACKS = 4,
	parameter int unsigned NUM_SLOTS  = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // stack_id[1:0], push_value[33:2], zero pad
	input  wire logic [0:0]  s_tuser,   // req_type[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [71:0] m_tdata    // status[1:0], popped_value[33:2],
	                                    // top_value[65:34], now_empty[66], zero pad
);

	localparam int unsigned AddrW = $clog2(NUM_SLOTS);
	localparam int unsigned PtrW  = AddrW + 1;
	localparam int unsigned ValW  = mss_pkg::ValueW;
	localparam int unsigned IdW   = mss_pkg::StackIdW;
	localparam logic [PtrW-1:0] Nil  = PtrW'(NUM_SLOTS);
	localparam logic [PtrW-1:0] Last = PtrW'(NUM_SLOTS - 1);

	// Unpack the input transfer.
	logic            in_req;
	logic [IdW-1:0]  in_sid;
	logic [ValW-1:0] in_val;

	assign in_req = s_tuser[0];
	assign in_sid = s_tdata[IdW-1:0];
	assign in_val = s_tdata[IdW+ValW-1:IdW];

	mss_pkg::state_t state_q, state_d;

	// Per-stack top pointer and cached top value; the data memory holds, for
	// each slot, the value of the element beneath it.
	logic [PtrW-1:0] top_q    [mss_pkg::NumIds];
	logic [ValW-1:0] topval_q [mss_pkg::NumIds];
	logic [PtrW-1:0] free_head_q;
	logic [PtrW-1:0] fill_q;    // links at or above this slot were never written

	// Request latched at accept.
	logic            req_s1;
	logic [IdW-1:0]  sid_s1;
	logic [ValW-1:0] val_s1;
	logic            known_s1;
	logic            err_s1;
	logic [PtrW-1:0] idx_s1;
	logic [PtrW-1:0] cur_top_s1;
	logic [ValW-1:0] cur_val_s1;

	logic            accept;
	logic            commit;
	logic            out_free;
	logic            in_known;
	logic [PtrW-1:0] in_top;
	logic [PtrW-1:0] in_idx;
	logic            in_err;

	logic [PtrW-1:0] link_rd;
	logic [ValW-1:0] data_rd;
	logic [PtrW-1:0] link_eff;
	logic            link_we;
	logic [PtrW-1:0] link_wdata;
	logic            data_we;

	mss_pkg::result_t res_d;
	mss_pkg::result_t res_q;

	assign accept   = s_tvalid && s_tready;
	assign in_known = 32'(in_sid) < 32'(NUM_STACKS);
	assign in_top   = top_q[in_sid];
	assign in_idx   = (in_req == mss_pkg::ReqPop) ? in_top : free_head_q;

	always_comb begin
		if (in_req == mss_pkg::ReqPop) begin
			in_err = !in_known || (in_top == Nil);
		end else begin
			in_err = !in_known || (free_head_q == Nil);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mss_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = mss_pkg::S_EXEC;
				end
			end
			mss_pkg::S_EXEC: begin
				if (out_free) begin
					state_d = mss_pkg::S_IDLE;
				end
			end
			default: state_d = mss_pkg::S_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			mss_pkg::S_IDLE: s_tready = 1'b1;
			mss_pkg::S_EXEC: commit   = out_free;
			default: begin
				s_tready = 1'b0;
				commit   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mss_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request and the addressed stack's state at accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= in_req;
			sid_s1     <= in_sid;
			val_s1     <= in_val;
			known_s1   <= in_known;
			err_s1     <= in_err;
			idx_s1     <= in_idx;
			cur_top_s1 <= in_top;
			cur_val_s1 <= topval_q[in_sid];
		end
	end

	// A never-written link reads as the next slot, the last slot as null.
	always_comb begin
		if (idx_s1 >= fill_q) begin
			link_eff = (idx_s1 == Last) ? Nil : idx_s1 + PtrW'(1);
		end else begin
			link_eff = link_rd;
		end
	end

	// Write back: push links the free head on top, pop returns the top slot.
	assign link_we    = commit && !err_s1;
	assign data_we    = commit && !err_s1 && (req_s1 == mss_pkg::ReqPush);
	assign link_wdata = (req_s1 == mss_pkg::ReqPush) ? cur_top_s1 : free_head_q;

	mss_slot_ram #(
		.DEPTH(NUM_SLOTS),
		.WIDTH(PtrW)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(idx_s1[AddrW-1:0]),
		.wdata(link_wdata),
		.re   (accept),
		.raddr(in_idx[AddrW-1:0]),
		.rdata(link_rd)
	);

	mss_slot_ram #(
		.DEPTH(NUM_SLOTS),
		.WIDTH(ValW)
	) u_data_ram (
		.clk  (clk),
		.we   (data_we),
		.waddr(idx_s1[AddrW-1:0]),
		.wdata(cur_val_s1),
		.re   (accept),
		.raddr(in_idx[AddrW-1:0]),
		.rdata(data_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(mss_pkg::NumIds); i++) begin
				top_q[i] <= Nil;
			end
			free_head_q <= '0;
			fill_q      <= '0;
		end else if (commit && !err_s1) begin
			if (req_s1 == mss_pkg::ReqPush) begin
				top_q[sid_s1] <= idx_s1;
				free_head_q   <= link_eff;
				if (idx_s1 >= fill_q) begin
					fill_q <= idx_s1 + PtrW'(1);
				end
			end else begin
				top_q[sid_s1] <= link_eff;
				free_head_q   <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && !err_s1) begin
			topval_q[sid_s1] <= (req_s1 == mss_pkg::ReqPush) ? val_s1 : data_rd;
		end
	end

	// Build the result for the output register.
	always_comb begin
		res_d = '0;
		priority if (err_s1 && (req_s1 == mss_pkg::ReqPush)) begin
			res_d.status    = mss_pkg::STAT_FULL;
			res_d.now_empty = !known_s1 || (cur_top_s1 == Nil);
			res_d.top_value = res_d.now_empty ? '0 : cur_val_s1;
		end else if (err_s1) begin
			res_d.status    = mss_pkg::STAT_EMPTY;
			res_d.now_empty = 1'b1;
		end else if (req_s1 == mss_pkg::ReqPush) begin
			res_d.status    = mss_pkg::STAT_DONE;
			res_d.top_value = val_s1;
			res_d.now_empty = 1'b0;
		end else begin
			res_d.status       = mss_pkg::STAT_DONE;
			res_d.popped_value = cur_val_s1;
			res_d.now_empty    = (link_eff == Nil);
			res_d.top_value    = res_d.now_empty ? '0 : data_rd;
		end
	end

	mss_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (commit),
		.res_in   (res_d),
		.free     (out_free),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.res_out  (res_q)
	);

	assign m_tdata = {5'b0, res_q.now_empty, res_q.top_value, res_q.popped_value,
		res_q.status};

endmodule

`default_nettype wire

/* design/mss_slot_ram.sv */
// Simple dual-port slot memory: one write port, one read port, registered read.
// Used for the slot data and slot link stores. No dependencies.
`default_nettype none

module mss_slot_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold read data until the next read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/mss_out_reg.sv */
// Output register for result transfers: holds one result until the sink takes it.
// Depends on mss_pkg for the result record.
`default_nettype none

module mss_out_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire mss_pkg::result_t res_in,
	output logic                 free,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output mss_pkg::result_t     res_out
);

	logic            valid_q;
	mss_pkg::result_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire

/* sim/tb_multi_stack_shared_store.sv */
// Testbench for multi_stack_shared_store: drives push and pop requests over the
// stream input and checks every result against a behavioral copy of the stacks
// or a typed row's given result. Depends on mss_pkg and multi_stack_shared_store.
`timescale 1ns / 1ps

module tb_multi_stack_shared_store;

	localparam int unsigned NumSlots   = 64;
	localparam int unsigned NumStacks  = 4;
	localparam int unsigned NilSlot    = NumSlots;   // end-of-chain marker
	localparam int          SegLen     = 90;         // length of a fill or drain segment
	localparam int          HoldCycles = 200;        // long receiver hold-off
	localparam int          StallLimit = 4000;       // cycles without any transfer
	localparam int          NumRows    = 23;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // stack_id[1:0], push_value[33:2], zero pad
	logic [0:0]  s_tuser;   // req_type[0]
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // status[1:0], popped_value[33:2], top_value[65:34],
	                        // now_empty[66], zero pad

	multi_stack_shared_store #(
		.NUM_STACKS(NumStacks),
		.NUM_SLOTS (NumSlots)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Shadow copy of the slot store: values, chain links, per-stack top and the
	// free-list head. NilSlot terminates every chain.
	logic [mss_pkg::ValueW-1:0] slot_val  [NumSlots];
	int unsigned                slot_next [NumSlots];
	int unsigned                top_slot  [NumStacks];
	int unsigned                free_slot;

	mss_pkg::result_t pending_results [$];   // expected results, oldest first
	int      mismatch_count = 0;
	int      send_idle_pct  = 0;
	int      recv_idle_pct  = 0;
	int      rand_index     = 0;
	int      idle_cycles    = 0;
	bit      hold_request   = 1'b0; // set by the stimulus, cleared by the receiver

	// Directed rows. Where 'typed' is set the expected result is given here;
	// otherwise the shadow store supplies it.
	typedef struct {
		logic                       op;
		logic [1:0]                 sid;
		logic [mss_pkg::ValueW-1:0] val;
		bit                         typed;
		mss_pkg::status_t           status;
		logic [mss_pkg::ValueW-1:0] popped;
		logic [mss_pkg::ValueW-1:0] top;
		logic                       empty;
	} dir_row_t;

	dir_row_t directed_rows [NumRows] = '{
		// pops of every stack straight after reset
		'{mss_pkg::ReqPop,  2'd0, 32'h0000_0000, 1'b1,
			mss_pkg::STAT_EMPTY, 32'h0, 32'h0, 1'b1},
		'{mss_pkg::ReqPop,  2'd1, 32'h0000_0000, 1'b1,
			mss_pkg::STAT_EMPTY, 32'h0, 32'h0, 1'b1},
		'{mss_pkg::ReqPop,  2'd2, 32'hFFFF_FFFF, 1'b1,
			mss_pkg::STAT_EMPTY, 32'h0, 32'h0, 1'b1},
		'{mss_pkg::ReqPop,  2'd3, 32'h0000_0000, 1'b1,
			mss_pkg::STAT_EMPTY, 32'h0, 32'h0, 1'b1},
		// extremes of the value range
		'{mss_pkg::ReqPush, 2'd0, 32'h7FFF_FFFF, 1'b1,
			mss_pkg::STAT_DONE, 32'h0, 32'h7FFF_FFFF, 1'b0},
		'{mss_pkg::ReqPush, 2'd0, 32'h8000_0000, 1'b1,
			mss_pkg::STAT_DONE, 32'h0, 32'h8000_0000, 1'b0},
		'{mss_pkg::ReqPush, 2'd1, 32'h0000_0000, 1'b1,
			mss_pkg::STAT_DONE, 32'h0, 32'h0000_0000, 1'b0},
		'{mss_pkg::ReqPush, 2'd1, 32'hFFFF_FFFF, 1'b1,
			mss_pkg::STAT_DONE, 32'h0, 32'hFFFF_FFFF, 1'b0},
		'{mss_pkg::ReqPush, 2'd2, 32'hAAAA_AAAA, 1'b1,
			mss_pkg::STAT_DONE, 32'h0, 32'hAAAA_AAAA, 1'b0},
		'{mss_pkg::ReqPush, 2'd3, 32'h5555_5555, 1'b1,
			mss_pkg::STAT_DONE, 32'h0, 32'h5555_5555, 1'b0},
		// pop carries a junk value that must be ignored
		'{mss_pkg::ReqPop,  2'd0, 32'hDEAD_BEEF, 1'b1,
			mss_pkg::STAT_DONE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0},
		'{mss_pkg::ReqPop,  2'd0, 32'h0000_0000, 1'b1,
			mss_pkg::STAT_DONE, 32'h7FFF_FFFF, 32'h0, 1'b1},
		'{mss_pkg::ReqPop,  2'd0, 32'h0000_0000, 1'b1,
			mss_pkg::STAT_EMPTY, 32'h0, 32'h0, 1'b1},
		'{mss_pkg::ReqPop,  2'd1, 32'h0000_0000, 1'b1,
			mss_pkg::STAT_DONE, 32'hFFFF_FFFF, 32'h0, 1'b0},
		// reuse of freed slots
		'{mss_pkg::ReqPush, 2'd3, 32'h1234_5678, 1'b0,
			mss_pkg::STAT_DONE, 32'h0, 32'h0, 1'b0},
		'{mss_pkg::ReqPush, 2'd2, 32'hFEDC_BA98, 1'b0,
			mss_pkg::STAT_DONE, 32'h0, 32'h0, 1'b0},
		'{mss_pkg::ReqPop,  2'd3, 32'hFFFF_FFFF, 1'b0,
			mss_pkg::STAT_DONE, 32'h0, 32'h0, 1'b0},
		'{mss_pkg::ReqPop,  2'd3, 32'h0000_0000, 1'b0,
			mss_pkg::STAT_DONE, 32'h0, 32'h0, 1'b0},
		'{mss_pkg::ReqPop,  2'd3, 32'h0000_0000, 1'b1,
			mss_pkg::STAT_EMPTY, 32'h0, 32'h0, 1'b1},
		'{mss_pkg::ReqPop,  2'd2, 32'h0000_0000, 1'b0,
			mss_pkg::STAT_DONE, 32'h0, 32'h0, 1'b0},
		'{mss_pkg::ReqPop,  2'd2, 32'h0000_0000, 1'b1,
			mss_pkg::STAT_DONE, 32'hAAAA_AAAA, 32'h0, 1'b1},
		'{mss_pkg::ReqPop,  2'd1, 32'h0000_0000, 1'b1,
			mss_pkg::STAT_DONE, 32'h0000_0000, 32'h0, 1'b1},
		'{mss_pkg::ReqPush, 2'd1, 32'h0F0F_0F0F, 1'b0,
			mss_pkg::STAT_DONE, 32'h0, 32'h0, 1'b0}
	};

	// Apply one request to the shadow store and return the result it gives.
	// Every 2-bit id names a real stack, so no id falls outside the set.
	function automatic mss_pkg::result_t apply_stack_op(input logic op,
			input logic [1:0] sid, input logic [mss_pkg::ValueW-1:0] val);
		mss_pkg::result_t res;
		int unsigned      idx;
		res.status       = mss_pkg::STAT_DONE;
		res.popped_value = '0;
		res.top_value    = '0;
		res.now_empty    = 1'b1;
		if (op == mss_pkg::ReqPush) begin
			if (free_slot == NilSlot) begin
				res.status = mss_pkg::STAT_FULL;
			end else begin
				// take the free-list head and link it on top of the stack
				idx            = free_slot;
				free_slot      = slot_next[idx];
				slot_val[idx]  = val;
				slot_next[idx] = top_slot[sid];
				top_slot[sid]  = idx;
			end
		end else begin
			if (top_slot[sid] == NilSlot) begin
				res.status = mss_pkg::STAT_EMPTY;
			end else begin
				// unlink the top slot and return it to the free-list head
				idx              = top_slot[sid];
				top_slot[sid]    = slot_next[idx];
				slot_next[idx]   = free_slot;
				free_slot        = idx;
				res.popped_value = slot_val[idx];
			end
		end
		if (top_slot[sid] != NilSlot) begin
			res.top_value = slot_val[top_slot[sid]];
			res.now_empty = 1'b0;
		end
		return res;
	endfunction

	// Offer one request, idling first at the sender's rate, and hold it until
	// the transfer. The expectation is queued at the accepting edge.
	task automatic send_req(input logic op, input logic [1:0] sid,
			input logic [mss_pkg::ValueW-1:0] val, input bit typed,
			input mss_pkg::result_t typed_want);
		mss_pkg::result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'b0, val, sid};
		do @(posedge clk); while (!s_tready);
		predicted = apply_stack_op(op, sid, val);
		pending_results.push_back(typed ? typed_want : predicted);
	endtask

	// Alternate push-heavy and pop-heavy segments so the store keeps running
	// into full and the stacks into empty, with the free list well scrambled.
	task automatic run_random(input int count);
		logic                       op;
		logic [1:0]                 sid;
		logic [mss_pkg::ValueW-1:0] val;
		bit                         filling;
		for (int k = 0; k < count; k++) begin
			filling = ((rand_index / SegLen) % 2) == 0;
			if ($urandom_range(99) < 90)
				op = filling ? mss_pkg::ReqPush : mss_pkg::ReqPop;
			else
				op = filling ? mss_pkg::ReqPop : mss_pkg::ReqPush;
			sid = 2'($urandom_range(NumStacks - 1));
			case ($urandom_range(9))
				0:       val = 32'h8000_0000;
				1:       val = 32'h7FFF_FFFF;
				2:       val = 32'h0000_0000;
				3:       val = 32'hFFFF_FFFF;
				default: val = $urandom;
			endcase
			rand_index++;
			send_req(op, sid, val, 1'b0, '0);
		end
	endtask

	// Hold until every queued expectation has been matched.
	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic compare_field(input string label,
			input logic [mss_pkg::ValueW-1:0] want, input logic [mss_pkg::ValueW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: drop m_tready at the current idle rate; on request, hold it low
	// for a long stretch so the block backs up into its input.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Result checker: each output transfer must match the oldest expectation.
	always @(posedge clk) begin
		mss_pkg::result_t got;
		mss_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = mss_pkg::result_t'(m_tdata[$bits(mss_pkg::result_t)-1:0]);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("status", mss_pkg::ValueW'(want.status),
					mss_pkg::ValueW'(got.status));
				compare_field("popped_value", want.popped_value, got.popped_value);
				compare_field("top_value", want.top_value, got.top_value);
				compare_field("now_empty", mss_pkg::ValueW'(want.now_empty),
					mss_pkg::ValueW'(got.now_empty));
			end
		end
	end

	// Watchdog: end the run if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == StallLimit) begin
			$display("%0t: no transfer for %0d cycles", $time, StallLimit);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= mss_pkg::ReqPush;
		arst_n   <= 1'b0;

		// Shadow store after reset: every slot chained to the next, stacks empty.
		for (int i = 0; i < NumSlots; i++) begin
			slot_val[i]  = '0;
			slot_next[i] = i + 1;
		end
		for (int i = 0; i < NumStacks; i++)
			top_slot[i] = NilSlot;
		free_slot = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase 1: sender rarely idles, receiver mostly stalls.
		send_idle_pct = 11;
		recv_idle_pct = 88;
		foreach (directed_rows[r]) begin
			send_req(directed_rows[r].op, directed_rows[r].sid, directed_rows[r].val,
				directed_rows[r].typed,
				'{now_empty:    directed_rows[r].empty,
				  top_value:    directed_rows[r].top,
				  popped_value: directed_rows[r].popped,
				  status:       directed_rows[r].status});
		end
		run_random(130);
		s_tvalid <= 1'b0;
		wait_drained();

		// Phase 2: the other way round.
		send_idle_pct = 88;
		recv_idle_pct = 11;
		run_random(130);
		s_tvalid <= 1'b0;
		wait_drained();

		// Phase 3: no idling, opened by a long receiver hold-off so the block
		// fills and stalls its input while requests keep coming.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request  = 1'b1;
		run_random(140);
		s_tvalid <= 1'b0;
		wait_drained();

		// Wait for any stray result to surface.
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
